// ===== rtl/jdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdq_pkg
// Shared types and codes of the job deque: operation codes, status codes and
// the request and result records passed between the front, queue and back.
// ----------------------------------------------------------------------------
package jdq_pkg;

  // Field widths on the stream ports
  localparam int ACTION_W   = 3;
  localparam int IN_ID_W    = 16;
  localparam int IN_PAY_W   = 32;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int REMOVED_W  = 5;
  localparam int OCC_W      = 5;

  // Action codes as they arrive on the input stream
  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CANCEL = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd4;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_CANCEL,
    OP_PEEK,
    OP_NOP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [IN_ID_W-1:0]  item_id;
    logic [IN_PAY_W-1:0] item_payload;
    logic [POS_W-1:0]    position;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [IN_ID_W-1:0]   out_id;
    logic [IN_PAY_W-1:0]  out_payload;
    logic [REMOVED_W-1:0] removed_count;
    logic [OCC_W-1:0]     occupancy;
  } res_t;

endpackage

// ===== rtl/jdq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdq_front
// Input stage: takes requests off the stream, decodes the action code into an
// operation and holds the decoded request until the queue takes it.
// ----------------------------------------------------------------------------
module jdq_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [2:0]              in_action_i,
  input  logic [15:0]             in_item_id_i,
  input  logic [31:0]             in_item_payload_i,
  input  logic [3:0]              in_position_i,
  output logic                    in_ready_o,
  output logic                    cmd_valid_o,
  output jdq_pkg::cmd_t           cmd_o,
  input  logic                    cmd_ready_i
);
  import jdq_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  op_e  op_dec;

  always_comb begin
    unique case (in_action_i)
      ACT_APPEND: op_dec = OP_APPEND;
      ACT_INSERT: op_dec = OP_INSERT;
      ACT_REMOVE: op_dec = OP_REMOVE;
      ACT_CANCEL: op_dec = OP_CANCEL;
      ACT_PEEK:   op_dec = OP_PEEK;
      default:    op_dec = OP_NOP;
    endcase
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q && !cmd_ready_i;
    cmd_d   = cmd_q;
    if (in_valid_i && in_ready_o) begin
      valid_d            = 1'b1;
      cmd_d.op           = op_dec;
      cmd_d.item_id      = in_item_id_i;
      cmd_d.item_payload = in_item_payload_i;
      cmd_d.position     = in_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// ===== rtl/jdq_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdq_cmd_fifo
// Two-entry request queue between the decoder and the executor, so that a
// long cancel does not stop the input side at once.
// ----------------------------------------------------------------------------
module jdq_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  jdq_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output jdq_pkg::cmd_t pop_cmd_o,
  input  logic          pop_ready_i
);
  import jdq_pkg::*;

  cmd_t       slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/jdq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdq_back
// Executor: owns the circular entry store, head and count, carries out one
// request at a time and registers its result for the output stream.
// ----------------------------------------------------------------------------
module jdq_back #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_WIDTH      = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  jdq_pkg::cmd_t cmd_i,
  output logic          cmd_ready_o,
  output logic          res_valid_o,
  output jdq_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import jdq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int EW = ID_WIDTH + PAYLOAD_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_CAN_RD,
    S_CAN_WR
  } state_e;

  // (base + off) mod depth, with base + off known to stay below twice depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  state_e                state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         kept_q, kept_d;
  logic [ID_WIDTH-1:0]   id_q, id_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_q, out_d;

  logic                     out_free;
  logic [ID_WIDTH-1:0]      in_id;
  logic [PAYLOAD_WIDTH-1:0] in_pay;
  logic [ID_WIDTH-1:0]      rd_id;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [PW-1:0]            pos_ext;
  logic                     is_full, is_empty;

  assign out_free    = !out_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign in_id    = ID_WIDTH'(cmd_i.item_id);
  assign in_pay   = PAYLOAD_WIDTH'(cmd_i.item_payload);
  assign rd_id    = rdata_q[EW-1 -: ID_WIDTH];
  assign rd_pay   = rdata_q[PAYLOAD_WIDTH-1:0];
  assign pos_ext  = PW'(cmd_i.position);
  assign is_full  = (count_q == DEPTH_C);
  assign is_empty = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = head_q;
    raddr       = head_q;
    wdata       = {in_id, in_pay};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          out_d.status        = STS_OK;
          out_d.out_id        = '0;
          out_d.out_payload   = '0;
          out_d.removed_count = '0;
          out_d.occupancy     = OCC_W'(count_q);
          unique case (cmd_i.op)
            OP_APPEND: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_d.status = STS_FULL;
              end else begin
                mem_we          = 1'b1;
                waddr           = slot_of(head_q, count_q);
                count_d         = count_q + 1'b1;
                out_d.occupancy = OCC_W'(count_d);
              end
            end
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_d.status = STS_FULL;
              end else begin
                head_d          = (head_q == '0) ? LAST_C : head_q - 1'b1;
                mem_we          = 1'b1;
                waddr           = head_d;
                count_d         = count_q + 1'b1;
                out_d.occupancy = OCC_W'(count_d);
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_d.status = STS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                raddr   = head_q;
                head_d  = slot_of(head_q, CW'(1));
                count_d = count_q - 1'b1;
                state_d = S_RESP;
              end
            end
            OP_PEEK: begin
              if (pos_ext >= PW'(count_q)) begin
                out_valid_d  = 1'b1;
                out_d.status = STS_RANGE;
              end else begin
                mem_re  = 1'b1;
                raddr   = slot_of(head_q, CW'(pos_ext));
                state_d = S_RESP;
              end
            end
            OP_CANCEL: begin
              id_d    = in_id;
              idx_d   = '0;
              kept_d  = '0;
              state_d = S_CAN_RD;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = STS_OK;
          out_d.out_id        = IN_ID_W'(rd_id);
          out_d.out_payload   = IN_PAY_W'(rd_pay);
          out_d.removed_count = '0;
          out_d.occupancy     = OCC_W'(count_q);
          state_d             = S_IDLE;
        end
      end
      S_CAN_RD: begin
        if (idx_q == count_q) begin
          // whole run scanned; survivors sit packed from the head
          if (out_free) begin
            out_valid_d         = 1'b1;
            out_d.status        = STS_OK;
            out_d.out_id        = '0;
            out_d.out_payload   = '0;
            out_d.removed_count = REMOVED_W'(count_q - kept_q);
            out_d.occupancy     = OCC_W'(kept_q);
            count_d             = kept_q;
            state_d             = S_IDLE;
          end
        end else begin
          mem_re  = 1'b1;
          raddr   = slot_of(head_q, idx_q);
          state_d = S_CAN_WR;
        end
      end
      S_CAN_WR: begin
        if (rd_id != id_q) begin
          mem_we = 1'b1;
          waddr  = slot_of(head_q, kept_q);
          wdata  = rdata_q;
          kept_d = kept_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_CAN_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      kept_q      <= kept_d;
      id_q        <= id_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

// ===== rtl/job_deque_with_cancel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_deque_with_cancel
// Bounded job deque with append, urgent insert, remove, peek and cancel by id.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Append, urgent insert, the error
// cases and unused action codes are finished by the executor in S_IDLE;
// remove and peek go on through S_RESP, as the entry store has one registered
// read port; a cancel reads each held entry (S_CAN_RD) and writes back the
// survivors in order (S_CAN_WR) through that same port. A two-entry request
// queue and an input register let up to three requests be taken while a
// cancel runs. The executor starts the next request only once the result
// register is free, which includes the cycle in which the waiting result is
// taken; a result left waiting holds the executor.
module job_deque_with_cancel #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int ID_WIDTH      = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // item_id[15:0], item_payload[47:16], position[51:48]
  input  logic [2:0]  s_axis_tuser_i,   // action[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // out_id[15:0], out_payload[47:16],
                                        // removed_count[52:48], occupancy[57:53]
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);
  import jdq_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic fifo_valid, fifo_ready;
  cmd_t fifo_cmd;
  res_t res;

  jdq_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid_i),
    .in_action_i       (s_axis_tuser_i),
    .in_item_id_i      (s_axis_tdata_i[15:0]),
    .in_item_payload_i (s_axis_tdata_i[47:16]),
    .in_position_i     (s_axis_tdata_i[51:48]),
    .in_ready_o        (s_axis_tready_o),
    .cmd_valid_o       (front_valid),
    .cmd_o             (front_cmd),
    .cmd_ready_i       (front_ready)
  );

  jdq_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_cmd_i   (front_cmd),
    .push_ready_o (front_ready),
    .pop_valid_o  (fifo_valid),
    .pop_cmd_o    (fifo_cmd),
    .pop_ready_i  (fifo_ready)
  );

  jdq_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .ID_WIDTH      (ID_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .cmd_ready_o (fifo_ready),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {6'b0, res.occupancy, res.removed_count, res.out_payload, res.out_id};
  assign m_axis_tuser_o = res.status;

  // failed requests carry no entry
  a_err_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != STS_OK) |-> (m_axis_tdata_o[47:0] == 48'd0))
    else $error("error result carries entry data");

  // only a cancel reports a removal count, and a cancel never returns an entry
  a_cancel_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[52:48] != 5'd0) |->
      (m_axis_tuser_o == STS_OK && m_axis_tdata_o[47:0] == 48'd0))
    else $error("removal count on a result that is not a cancel");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (QUEUE_DEPTH > 31 || m_axis_tdata_o[57:53] <= 5'(QUEUE_DEPTH)))
    else $error("occupancy beyond queue depth");

  // a full report means the store really was full
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STS_FULL) |->
      (QUEUE_DEPTH > 31 || m_axis_tdata_o[57:53] == 5'(QUEUE_DEPTH)))
    else $error("full status below queue depth");

endmodule
